// ===== hdl/msjd_pkg.sv =====
// Shared types, widths, codes and reset values for the multi-server job dispatcher.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package msjd_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int MAX_JOBS_DEF    = 64;
  localparam int NUM_SERVERS_DEF = 3;

  // Field widths.
  localparam int OP_W      = 2;
  localparam int TAG_W     = 16;
  localparam int SIZE_W    = 20;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SIDX_W    = 2;

  // Command codes on the input channel.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATE0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd3;

  // Configuration reset values.
  localparam logic [RATE_W-1:0] RATE0_RST = 16'd300;
  localparam logic [RATE_W-1:0] RATE1_RST = 16'd400;
  localparam logic [RATE_W-1:0] RATE2_RST = 16'd500;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued command.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [RATE_W-1:0] rate0;
    logic [RATE_W-1:0] rate1;
    logic [RATE_W-1:0] rate2;
    logic              sjf;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/msjd_front.sv =====
// Front end of the dispatcher: accepts commands, drops unused codes and queues the rest.
// Depends on msjd_pkg.
`default_nettype none

module msjd_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire  [msjd_pkg::OP_W-1:0]   in_op,
  input  wire  [msjd_pkg::TAG_W-1:0]  in_job_tag,
  input  wire  [msjd_pkg::SIZE_W-1:0] in_job_size,
  output logic                      cmd_valid,
  output msjd_pkg::cmd_t            cmd,
  input  wire                       cmd_pop
);
  import msjd_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              known_op;
  logic              push;

  // A transfer needs start and a queue with room; unused codes are dropped here.
  assign busy      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign known_op  = (in_op == OP_LOAD) || (in_op == OP_TICK) || (in_op == OP_CLEAR);
  assign push      = accept && known_op;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: in_op, tag: in_job_tag, size: in_job_size};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msjd_back.sv =====
// Back end of the dispatcher: job store, per-server state and the pick sequencer.
// Depends on msjd_pkg; fed by msjd_front through the command queue.
`default_nettype none

module msjd_back #(
  parameter int MAX_JOBS    = msjd_pkg::MAX_JOBS_DEF,
  parameter int NUM_SERVERS = msjd_pkg::NUM_SERVERS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  msjd_pkg::cfg_t        cfg,
  input  wire                         cmd_valid,
  input  wire  msjd_pkg::cmd_t        cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  output logic [msjd_pkg::SIDX_W-1:0] out_server_index,
  output logic                        out_busy_res,
  output logic [msjd_pkg::TAG_W-1:0]  out_current_tag,
  output logic [msjd_pkg::RATE_W-1:0] out_done_amount,
  output logic                        out_last
);
  import msjd_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_JOBS);
  localparam logic [SRV_W-1:0] SRV_LAST = SRV_W'(NUM_SERVERS - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SERVER = 3'd1;
  localparam logic [2:0] ST_FREQ   = 3'd2;
  localparam logic [2:0] ST_FCHK   = 3'd3;
  localparam logic [2:0] ST_SSCAN  = 3'd4;

  // Job store.
  logic [TAG_W-1:0]  tag_mem   [MAX_JOBS];
  logic [SIZE_W-1:0] size_mem  [MAX_JOBS];
  logic              taken_mem [MAX_JOBS];
  logic [TAG_W-1:0]  rd_tag_r;
  logic [SIZE_W-1:0] rd_size_r;
  logic              rd_taken_r;

  // Control state.
  logic [2:0]       state_r, state_nxt;
  logic [SRV_W-1:0] srv_r, srv_nxt;
  logic [CNT_W-1:0] job_cnt_r, job_cnt_nxt;
  logic [CNT_W-1:0] fifo_ptr_r, fifo_ptr_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [TAG_W-1:0]  best_tag_r, best_tag_nxt;

  // Per-server state.
  logic [SIZE_W-1:0] rem_r [NUM_SERVERS];
  logic [SIZE_W-1:0] rem_nxt [NUM_SERVERS];
  logic [TAG_W-1:0]  tag_r [NUM_SERVERS];
  logic [TAG_W-1:0]  tag_nxt [NUM_SERVERS];
  logic              act_r [NUM_SERVERS];
  logic              act_nxt [NUM_SERVERS];

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [SIDX_W-1:0] out_sidx_r, out_sidx_nxt;
  logic              out_busy_r, out_busy_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic [RATE_W-1:0] out_done_r, out_done_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory controls.
  logic             load_we;
  logic             taken_we;
  logic [IDX_W-1:0] taken_wa;
  logic             taken_wd;
  logic [IDX_W-1:0] rd_addr;

  // Server finish path: one result per server.
  logic              fin_go;
  logic              fin_act;
  logic [TAG_W-1:0]  fin_tag;
  logic [SIZE_W-1:0] fin_rem;
  logic [RATE_W-1:0] rate_raw;
  logic [RATE_W-1:0] rate_eff;
  logic [SIZE_W-1:0] done_amt;

  // Rate of the current server; a zero rate acts as one.
  always_comb begin
    if (srv_r == '0) begin
      rate_raw = cfg.rate0;
    end else if (srv_r == SRV_W'(1)) begin
      rate_raw = cfg.rate1;
    end else begin
      rate_raw = cfg.rate2;
    end
    rate_eff = (rate_raw == '0) ? RATE_W'(1) : rate_raw;
    done_amt = (fin_rem < SIZE_W'(rate_eff)) ? fin_rem : SIZE_W'(rate_eff);
  end

  // Sequencer: executes one queued command, stepping through the servers on a tick.
  always_comb begin
    state_nxt     = state_r;
    srv_nxt       = srv_r;
    job_cnt_nxt   = job_cnt_r;
    fifo_ptr_nxt  = fifo_ptr_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    best_tag_nxt  = best_tag_r;
    rem_nxt       = rem_r;
    tag_nxt       = tag_r;
    act_nxt       = act_r;
    out_valid_nxt = 1'b0;
    out_sidx_nxt  = out_sidx_r;
    out_busy_nxt  = out_busy_r;
    out_tag_nxt   = out_tag_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    load_we       = 1'b0;
    taken_we      = 1'b0;
    taken_wa      = job_cnt_r[IDX_W-1:0];
    taken_wd      = 1'b0;
    rd_addr       = fifo_ptr_r[IDX_W-1:0];
    fin_go        = 1'b0;
    fin_act       = 1'b0;
    fin_tag       = '0;
    fin_rem       = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_LOAD: begin
              // A load into a full store is dropped.
              if (job_cnt_r < CNT_MAX) begin
                load_we     = 1'b1;
                taken_we    = 1'b1;
                taken_wa    = job_cnt_r[IDX_W-1:0];
                taken_wd    = 1'b0;
                job_cnt_nxt = job_cnt_r + 1'b1;
              end
            end
            OP_TICK: begin
              srv_nxt   = '0;
              state_nxt = ST_SERVER;
            end
            OP_CLEAR: begin
              job_cnt_nxt  = '0;
              fifo_ptr_nxt = '0;
              for (int s = 0; s < NUM_SERVERS; s++) begin
                rem_nxt[s] = '0;
                tag_nxt[s] = '0;
                act_nxt[s] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SERVER: begin
        if (rem_r[srv_r] != '0) begin
          // Job still running.
          fin_go  = 1'b1;
          fin_act = 1'b1;
          fin_tag = tag_r[srv_r];
          fin_rem = rem_r[srv_r];
        end else if (!cfg.sjf) begin
          state_nxt = ST_FREQ;
        end else begin
          scan_idx_nxt = '0;
          best_vld_nxt = 1'b0;
          state_nxt    = ST_SSCAN;
        end
      end

      ST_FREQ: begin
        // The FCFS pointer is a lower bound on the oldest untaken slot.
        if (fifo_ptr_r < job_cnt_r) begin
          rd_addr   = fifo_ptr_r[IDX_W-1:0];
          state_nxt = ST_FCHK;
        end else begin
          fin_go = 1'b1;
        end
      end

      ST_FCHK: begin
        if (rd_taken_r) begin
          fifo_ptr_nxt = fifo_ptr_r + 1'b1;
          state_nxt    = ST_FREQ;
        end else begin
          taken_we = 1'b1;
          taken_wa = fifo_ptr_r[IDX_W-1:0];
          taken_wd = 1'b1;
          fin_go   = 1'b1;
          fin_act  = 1'b1;
          fin_tag  = rd_tag_r;
          fin_rem  = rd_size_r;
        end
      end

      ST_SSCAN: begin
        // Compare the entry read last cycle; strict less keeps the earlier load on ties.
        if (rd_vld_r && !rd_taken_r && (!best_vld_r || rd_size_r < best_size_r)) begin
          best_vld_nxt  = 1'b1;
          best_idx_nxt  = rd_idx_r[IDX_W-1:0];
          best_size_nxt = rd_size_r;
          best_tag_nxt  = rd_tag_r;
        end
        if (scan_idx_r < job_cnt_r) begin
          rd_addr      = scan_idx_r[IDX_W-1:0];
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_idx_r;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else if (!rd_vld_r) begin
          // Scan drained: take the smallest job, if any.
          fin_go = 1'b1;
          if (best_vld_r) begin
            taken_we = 1'b1;
            taken_wa = best_idx_r;
            taken_wd = 1'b1;
            fin_act  = 1'b1;
            fin_tag  = best_tag_r;
            fin_rem  = best_size_r;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Report the current server and move to the next one.
    if (fin_go) begin
      rem_nxt[srv_r] = fin_act ? (fin_rem - done_amt) : '0;
      tag_nxt[srv_r] = fin_act ? fin_tag : '0;
      act_nxt[srv_r] = fin_act;
      out_valid_nxt  = 1'b1;
      out_sidx_nxt   = SIDX_W'(srv_r);
      out_busy_nxt   = fin_act;
      out_tag_nxt    = fin_act ? fin_tag : '0;
      out_done_nxt   = fin_act ? done_amt[RATE_W-1:0] : '0;
      out_last_nxt   = (srv_r == SRV_LAST);
      if (srv_r == SRV_LAST) begin
        state_nxt = ST_IDLE;
      end else begin
        srv_nxt   = srv_r + 1'b1;
        state_nxt = ST_SERVER;
      end
    end
  end

  // Control and server state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      srv_r       <= '0;
      job_cnt_r   <= '0;
      fifo_ptr_r  <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        rem_r[s] <= '0;
        tag_r[s] <= '0;
        act_r[s] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      srv_r       <= srv_nxt;
      job_cnt_r   <= job_cnt_nxt;
      fifo_ptr_r  <= fifo_ptr_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      tag_r       <= tag_nxt;
      act_r       <= act_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    best_tag_r  <= best_tag_nxt;
    out_sidx_r  <= out_sidx_nxt;
    out_busy_r  <= out_busy_nxt;
    out_tag_r   <= out_tag_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Job store memories with registered reads.
  always_ff @(posedge clk) begin
    if (load_we) begin
      tag_mem[job_cnt_r[IDX_W-1:0]]  <= cmd.tag;
      size_mem[job_cnt_r[IDX_W-1:0]] <= cmd.size;
    end
    if (taken_we) begin
      taken_mem[taken_wa] <= taken_wd;
    end
    rd_tag_r   <= tag_mem[rd_addr];
    rd_size_r  <= size_mem[rd_addr];
    rd_taken_r <= taken_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_server_index = out_sidx_r;
  assign out_busy_res     = out_busy_r;
  assign out_current_tag  = out_tag_r;
  assign out_done_amount  = out_done_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/multi_server_job_dispatcher.sv =====
// Top level: configuration registers, a two-command front queue and the execution back end.
// Flow: the front queues each command; the back pops one only when idle, and a tick then
//   steps the servers in order. A server with a running job reports it; else a FCFS pick
//   walks the store from the FCFS pointer past taken slots, and a SJF pick scans it all.
// Results cannot be stalled; a new command waits until a tick has reported every server.
// Reset: synchronous active-low; store empty, servers idle, rates 300/400/500, FCFS mode.
`default_nettype none

module multi_server_job_dispatcher #(
  parameter int MAX_JOBS    = msjd_pkg::MAX_JOBS_DEF,
  parameter int NUM_SERVERS = msjd_pkg::NUM_SERVERS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [msjd_pkg::OP_W-1:0]      in_op,
  input  wire  [msjd_pkg::TAG_W-1:0]     in_job_tag,
  input  wire  [msjd_pkg::SIZE_W-1:0]    in_job_size,
  output logic                           out_valid,
  output logic [msjd_pkg::SIDX_W-1:0]    out_server_index,
  output logic                           out_busy_res,
  output logic [msjd_pkg::TAG_W-1:0]     out_current_tag,
  output logic [msjd_pkg::RATE_W-1:0]    out_done_amount,
  output logic                           out_last,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [msjd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [msjd_pkg::RATE_W-1:0]    cfg_data
);
  import msjd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_RATE0: cfg_nxt.rate0 = cfg_data;
        REG_RATE1: cfg_nxt.rate1 = cfg_data;
        REG_RATE2: cfg_nxt.rate2 = cfg_data;
        REG_MODE:  cfg_nxt.sjf   = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rate0: RATE0_RST, rate1: RATE1_RST, rate2: RATE2_RST, sjf: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Command intake and queue.
  msjd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_job_tag  (in_job_tag),
    .in_job_size (in_job_size),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // Job store, servers and pick sequencer.
  msjd_back #(
    .MAX_JOBS    (MAX_JOBS),
    .NUM_SERVERS (NUM_SERVERS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_server_index (out_server_index),
    .out_busy_res     (out_busy_res),
    .out_current_tag  (out_current_tag),
    .out_done_amount  (out_done_amount),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== hdl/msjd_checker.sv =====
// Port-level checks for the multi-server job dispatcher, bound to the top level.
// Depends on msjd_pkg and the multi_server_job_dispatcher ports.
`default_nettype none

module msjd_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            busy,
  input wire                            out_valid,
  input wire [msjd_pkg::SIDX_W-1:0]     out_server_index,
  input wire                            out_busy_res,
  input wire [msjd_pkg::TAG_W-1:0]      out_current_tag,
  input wire [msjd_pkg::RATE_W-1:0]     out_done_amount,
  input wire                            out_last
);

  // Reset leaves no result pending and the queue open.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy seen right after reset");

  // An idle server reports neither a tag nor completed work.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_current_tag == '0 && out_done_amount == '0)
    else $error("idle result carries a tag or work");

  // The final result of a tick is followed by a gap.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result transfer right after the final one of a tick");

  // Back-to-back results within a tick come from consecutive servers.
  a_srv_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_last)
      |-> out_server_index == $past(out_server_index) + 1'b1)
    else $error("server results out of order");

endmodule

bind multi_server_job_dispatcher msjd_checker u_msjd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_server_index (out_server_index),
  .out_busy_res     (out_busy_res),
  .out_current_tag  (out_current_tag),
  .out_done_amount  (out_done_amount),
  .out_last         (out_last)
);

`default_nettype wire
